// ----- rtl/kruskal_union_find_engine_defines.svh -----
// Assertion macros for the kufe modules, used by kufe_dsu.
// Needs clk and rst_n in the scope of each use.
`ifndef KRUSKAL_UNION_FIND_ENGINE_DEFINES_SVH
`define KRUSKAL_UNION_FIND_ENGINE_DEFINES_SVH

// same-cycle implication
`define KUFE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KUFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/kufe_pkg.sv -----
// Types, widths and helpers for the Kruskal union-find engine.
// No dependencies.
package kufe_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int IDX_W      = $clog2(MAX_NODES);
  localparam int SIZE_W     = $clog2(MAX_NODES + 1);
  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int NODE_W     = 11;
  localparam int WEIGHT_W   = 32;
  localparam int COST_W     = 48;
  localparam int RED_W      = 32;
  localparam int JOIN_W     = 10;
  localparam int NODE_RESET = 1024;

  typedef enum logic {
    OP_EDGE  = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_COMP,
    S_MERGE,
    S_JOIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              root;
    logic [IDX_W-1:0]  parent;
    logic [SIZE_W-1:0] size;
  } node_word_t;

  typedef struct packed {
    logic                clear;
    logic                taken;
    logic                redundant;
    logic [WEIGHT_W-1:0] weight;
  } done_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [NODE_W-1:0] n);
    logic [CNT_W-1:0] res;
    if (n == '0) begin
      res = CNT_W'(1);
    end else if (32'(n) > MAX_NODES) begin
      res = CNT_W'(MAX_NODES);
    end else begin
      res = CNT_W'(n);
    end
    return res;
  endfunction

endpackage

// ----- rtl/kufe_in_if.sv -----
// Edge input channel: valid/ready plus the edge command payload.
// Depends on kufe_pkg.
interface kufe_in_if;
  import kufe_pkg::*;

  logic                valid;
  logic                ready;
  logic                opcode;
  logic [NODE_W-1:0]   node_a;
  logic [NODE_W-1:0]   node_b;
  logic [WEIGHT_W-1:0] weight;

  modport source (output valid, opcode, node_a, node_b, weight, input ready);
  modport sink   (input valid, opcode, node_a, node_b, weight, output ready);
endinterface

// ----- rtl/kufe_out_if.sv -----
// Result channel: valid/ready plus the per-edge result and running totals.
// Depends on kufe_pkg.
interface kufe_out_if;
  import kufe_pkg::*;

  logic              valid;
  logic              ready;
  logic              edge_taken;
  logic [COST_W-1:0] total_cost;
  logic [RED_W-1:0]  redundant_count;
  logic [JOIN_W-1:0] tree_edges;
  logic              spanning;

  modport source (output valid, edge_taken, total_cost, redundant_count, tree_edges,
                  spanning, input ready);
  modport sink   (input valid, edge_taken, total_cost, redundant_count, tree_edges,
                  spanning, output ready);
endinterface

// ----- rtl/kufe_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kufe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/kufe_dsu.sv -----
// Disjoint-set sequencer: leader search with path compression, union by size,
// clearing sweep. Depends on kufe_pkg, kufe_in_if, kufe_ram and the defines header.
`include "kruskal_union_find_engine_defines.svh"

module kufe_dsu (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [kufe_pkg::CNT_W-1:0] eff_n,
  kufe_in_if.sink               in_ch,
  output logic                  done_valid,
  input  logic                  done_ready,
  output kufe_pkg::done_t       done
);
  import kufe_pkg::*;

  localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(MAX_NODES - 1);

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0]    idx_a_r, idx_a_nxt;
  logic [IDX_W-1:0]    idx_b_r, idx_b_nxt;
  logic [IDX_W-1:0]    cur_r, cur_nxt;
  logic [IDX_W-1:0]    root_r, root_nxt;
  logic [SIZE_W-1:0]   root_size_r, root_size_nxt;
  logic [IDX_W-1:0]    la_r, la_nxt;
  logic [SIZE_W-1:0]   size_a_r, size_a_nxt;
  logic [IDX_W-1:0]    keep_r, keep_nxt;
  logic [SIZE_W-1:0]   sum_r, sum_nxt;
  logic                phase_b_r, phase_b_nxt;
  logic                clear_r, clear_nxt;
  logic                taken_r, taken_nxt;
  logic                redundant_r, redundant_nxt;
  logic [WEIGHT_W-1:0] weight_r, weight_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  node_word_t          ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [$bits(node_word_t)-1:0] ram_rdata;
  node_word_t          rword;
  logic                ends_ok;

  kufe_ram #(
    .WIDTH ($bits(node_word_t)),
    .DEPTH (MAX_NODES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rword   = node_word_t'(ram_rdata);
  assign ends_ok = (in_ch.node_a != '0) && (32'(in_ch.node_a) <= 32'(eff_n)) &&
                   (in_ch.node_b != '0) && (32'(in_ch.node_b) <= 32'(eff_n));

  assign in_ch.ready     = (state_r == S_IDLE);
  assign done_valid      = (state_r == S_DONE);
  assign done.clear      = clear_r;
  assign done.taken      = taken_r;
  assign done.redundant  = redundant_r;
  assign done.weight     = weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      clear_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      clear_r   <= clear_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_a_r     <= idx_a_nxt;
    idx_b_r     <= idx_b_nxt;
    cur_r       <= cur_nxt;
    root_r      <= root_nxt;
    root_size_r <= root_size_nxt;
    la_r        <= la_nxt;
    size_a_r    <= size_a_nxt;
    keep_r      <= keep_nxt;
    sum_r       <= sum_nxt;
    phase_b_r   <= phase_b_nxt;
    taken_r     <= taken_nxt;
    redundant_r <= redundant_nxt;
    weight_r    <= weight_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    idx_a_nxt     = idx_a_r;
    idx_b_nxt     = idx_b_r;
    cur_nxt       = cur_r;
    root_nxt      = root_r;
    root_size_nxt = root_size_r;
    la_nxt        = la_r;
    size_a_nxt    = size_a_r;
    keep_nxt      = keep_r;
    sum_nxt       = sum_r;
    phase_b_nxt   = phase_b_r;
    clear_nxt     = clear_r;
    taken_nxt     = taken_r;
    redundant_nxt = redundant_r;
    weight_nxt    = weight_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = cur_r;

    unique case (state_r)
      S_CLEAR: begin
        ram_we           = 1'b1;
        ram_waddr        = clr_cnt_r;
        ram_wdata.root   = 1'b1;
        ram_wdata.parent = clr_cnt_r;
        ram_wdata.size   = SIZE_W'(1);
        clr_cnt_nxt      = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == CLR_LAST) begin
          clr_cnt_nxt = '0;
          state_nxt   = clear_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          idx_a_nxt     = IDX_W'(in_ch.node_a - NODE_W'(1));
          idx_b_nxt     = IDX_W'(in_ch.node_b - NODE_W'(1));
          weight_nxt    = in_ch.weight;
          clear_nxt     = (in_ch.opcode == OP_CLEAR);
          taken_nxt     = 1'b0;
          redundant_nxt = 1'b0;
          phase_b_nxt   = 1'b0;
          if (in_ch.opcode == OP_CLEAR) begin
            state_nxt = S_CLEAR;
          end else if (ends_ok) begin
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(in_ch.node_a - NODE_W'(1));
            cur_nxt   = IDX_W'(in_ch.node_a - NODE_W'(1));
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_WALK: begin
        ram_re = 1'b1;
        if (rword.root) begin
          root_nxt      = cur_r;
          root_size_nxt = rword.size;
          ram_raddr     = phase_b_r ? idx_b_r : idx_a_r;
          cur_nxt       = phase_b_r ? idx_b_r : idx_a_r;
          state_nxt     = S_COMP;
        end else begin
          ram_raddr = rword.parent;
          cur_nxt   = rword.parent;
        end
      end
      S_COMP: begin
        if ((cur_r == root_r) || rword.root) begin
          if (!phase_b_r) begin
            la_nxt      = root_r;
            size_a_nxt  = root_size_r;
            phase_b_nxt = 1'b1;
            ram_re      = 1'b1;
            ram_raddr   = idx_b_r;
            cur_nxt     = idx_b_r;
            state_nxt   = S_WALK;
          end else begin
            state_nxt = S_MERGE;
          end
        end else begin
          // relink the visited node straight to its leader
          ram_we           = 1'b1;
          ram_waddr        = cur_r;
          ram_wdata.root   = 1'b0;
          ram_wdata.parent = root_r;
          ram_wdata.size   = rword.size;
          ram_re           = 1'b1;
          ram_raddr        = rword.parent;
          cur_nxt          = rword.parent;
        end
      end
      S_MERGE: begin
        if (la_r == root_r) begin
          redundant_nxt = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          ram_we           = 1'b1;
          ram_wdata.root   = 1'b0;
          sum_nxt          = size_a_r + root_size_r;
          taken_nxt        = 1'b1;
          if (size_a_r > root_size_r) begin
            keep_nxt         = la_r;
            ram_waddr        = root_r;
            ram_wdata.parent = la_r;
            ram_wdata.size   = root_size_r;
          end else begin
            keep_nxt         = root_r;
            ram_waddr        = la_r;
            ram_wdata.parent = root_r;
            ram_wdata.size   = size_a_r;
          end
          state_nxt = S_JOIN;
        end
      end
      S_JOIN: begin
        ram_we           = 1'b1;
        ram_waddr        = keep_r;
        ram_wdata.root   = 1'b1;
        ram_wdata.parent = keep_r;
        ram_wdata.size   = sum_r;
        state_nxt        = S_DONE;
      end
      S_DONE: begin
        if (done_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  `KUFE_ASSERT(a_comp_keeps_root, (state_r == S_COMP) && ram_we, ram_waddr != root_r, "compression wrote the leader")
  `KUFE_ASSERT(a_merge_no_self, (state_r == S_MERGE) && ram_we, ram_wdata.parent != ram_waddr, "merge linked a leader to itself")
  `KUFE_ASSERT_NEXT(a_sweep_step, (state_r == S_CLEAR) && (clr_cnt_r != CLR_LAST), clr_cnt_r == $past(clr_cnt_r) + IDX_W'(1), "clearing sweep skipped an entry")

endmodule

// ----- rtl/kufe_totals.sv -----
// Running totals (cost, redundant and tree edge counts) and the result register.
// Depends on kufe_pkg and kufe_out_if.
module kufe_totals (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [kufe_pkg::CNT_W-1:0] eff_n,
  input  logic                       done_valid,
  output logic                       done_ready,
  input  kufe_pkg::done_t            done,
  kufe_out_if.source                 out_ch
);
  import kufe_pkg::*;

  logic [COST_W-1:0] cost_r, cost_nxt;
  logic [RED_W-1:0]  red_r, red_nxt;
  logic [JOIN_W-1:0] joined_r, joined_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              taken_out_r, taken_out_nxt;
  logic              span_r, span_nxt;
  logic [COST_W:0]   cost_add;
  logic              xfer;

  assign done_ready = !out_valid_r || out_ch.ready;
  assign xfer       = done_valid && done_ready;
  assign cost_add   = {1'b0, cost_r} + (COST_W + 1)'(done.weight);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r      <= '0;
      red_r       <= '0;
      joined_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cost_r      <= cost_nxt;
      red_r       <= red_nxt;
      joined_r    <= joined_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    taken_out_r <= taken_out_nxt;
    span_r      <= span_nxt;
  end

  always_comb begin
    cost_nxt      = cost_r;
    red_nxt       = red_r;
    joined_nxt    = joined_r;
    taken_out_nxt = taken_out_r;
    span_nxt      = span_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (xfer) begin
      out_valid_nxt = 1'b1;
      if (done.clear) begin
        cost_nxt   = '0;
        red_nxt    = '0;
        joined_nxt = '0;
      end else if (done.taken) begin
        cost_nxt = cost_add[COST_W] ? '1 : cost_add[COST_W-1:0];
        if (joined_r != '1) begin
          joined_nxt = joined_r + JOIN_W'(1);
        end
      end else if (done.redundant) begin
        if (red_r != '1) begin
          red_nxt = red_r + RED_W'(1);
        end
      end
      taken_out_nxt = done.taken;
      span_nxt      = (32'(joined_nxt) == (32'(eff_n) - 32'd1));
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.edge_taken      = taken_out_r;
  assign out_ch.total_cost      = cost_r;
  assign out_ch.redundant_count = red_r;
  assign out_ch.tree_edges      = joined_r;
  assign out_ch.spanning        = span_r;

endmodule

// ----- rtl/kruskal_union_find_engine.sv -----
// Kruskal edge engine: node count register, disjoint-set sequencer, totals.
// Depends on kufe_pkg, kufe_in_if, kufe_out_if, kufe_dsu and kufe_totals.
//
// Usage: edges sorted by non-decreasing weight are sent on in_ch (opcode edge
// or clear); each transfer gives exactly one result on out_ch with the
// edge_taken flag and the running totals. cfg_wr_en/cfg_wr_data set the node
// count; the user must set it only while the block is idle (not enforced).
// One item is in work at a time. For an edge, the parent chain of each
// endpoint is walked once to its leader and once more to relink it, one
// read of the node store per step; then S_MERGE links one leader under the
// other by size and S_JOIN writes the kept leader. A redundant edge gives
// its result straight after S_MERGE, without S_JOIN. The next transfer is
// taken once the result leaves the sequencer.
// Endpoints outside the node count go from the transfer straight to the
// result, with no read of the node store.
// A clear, and reset, sweep the node store one entry a cycle, all 1024
// entries, in_ch.ready low throughout; a clear's result follows the sweep.
// A finished result waits in the output register while out_ch stalls; the
// next edge is taken in meanwhile and holds in its final state until the
// register frees.
module kruskal_union_find_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  kufe_in_if.sink                     in_ch,
  kufe_out_if.source                  out_ch,
  input  logic                        cfg_wr_en,
  input  logic [kufe_pkg::NODE_W-1:0] cfg_wr_data
);
  import kufe_pkg::*;

  logic [NODE_W-1:0] node_count_r;
  logic [CNT_W-1:0]  eff_n;
  logic              done_valid;
  logic              done_ready;
  done_t             done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_W'(NODE_RESET);
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  assign eff_n = eff_count(node_count_r);

  kufe_dsu u_dsu (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_n      (eff_n),
    .in_ch      (in_ch),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done       (done)
  );

  kufe_totals u_totals (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_n      (eff_n),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done       (done),
    .out_ch     (out_ch)
  );

endmodule

// ----- tb/tb_kruskal_union_find_engine.sv -----
// Self-checking testbench for kruskal_union_find_engine: drives edge and clear commands
// with random gaps and stalls, predicts every result with a disjoint-set model of its own.
// Depends on kufe_pkg, kufe_in_if, kufe_out_if and the engine RTL.
module tb_kruskal_union_find_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import kufe_pkg::*;

  typedef struct packed {
    opcode_t             op;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] weight;
  } edge_cmd_t;

  typedef struct packed {
    logic              taken;
    logic [COST_W-1:0] cost;
    logic [RED_W-1:0]  dups;
    logic [JOIN_W-1:0] joins;
    logic              span;
  } totals_t;

  localparam logic [COST_W-1:0] COST_SAT = '1;
  localparam logic [RED_W-1:0]  DUP_SAT  = '1;
  localparam logic [JOIN_W-1:0] JOIN_SAT = '1;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [NODE_W-1:0] cfg_wr_data;

  kufe_in_if  in_ch();
  kufe_out_if out_ch();

  kruskal_union_find_engine dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // disjoint-set shadow
  logic [IDX_W-1:0]  up_link [MAX_NODES];
  bit                is_leader [MAX_NODES];
  logic [SIZE_W-1:0] members [MAX_NODES];
  logic [COST_W-1:0] cost_acc;
  logic [RED_W-1:0]  dup_acc;
  logic [JOIN_W-1:0] tree_acc;
  logic [NODE_W-1:0] node_limit;

  edge_cmd_t edge_cmds[$];
  totals_t   totals_due[$];

  int fail_count;
  int accepted;
  int results_seen;
  int n_joins, n_dups, n_ignored, n_clears, n_span, n_settings;

  bit in_taken;
  bit in_gaps_on;
  bit out_stalls_on;
  bit hold_off;
  int gap_left;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) begin
      $display("[%0t] MISMATCH %s", $time, msg);
    end
  endtask

  function automatic int unsigned live_nodes();
    int unsigned n;
    n = node_limit;
    if (n == 0) begin
      n = 1;
    end else if (n > MAX_NODES) begin
      n = MAX_NODES;
    end
    return n;
  endfunction

  function automatic void clear_store();
    for (int i = 0; i < MAX_NODES; i++) begin
      up_link[i] = IDX_W'(i);
      is_leader[i] = 1'b1;
      members[i] = SIZE_W'(1);
    end
    cost_acc = '0;
    dup_acc = '0;
    tree_acc = '0;
  endfunction

  // leader lookup with path compression
  function automatic int unsigned leader_of(input int unsigned idx);
    int unsigned root;
    int unsigned cur;
    int unsigned nxt;
    int unsigned steps;
    root = idx;
    steps = 0;
    while (!is_leader[root] && steps < MAX_NODES) begin
      root = up_link[root];
      steps++;
    end
    cur = idx;
    steps = 0;
    while (cur != root && !is_leader[cur] && steps < MAX_NODES) begin
      nxt = up_link[cur];
      up_link[cur] = IDX_W'(root);
      cur = nxt;
      steps++;
    end
    return root;
  endfunction

  function automatic totals_t apply_edge_cmd(input edge_cmd_t c);
    totals_t r;
    int unsigned n;
    int unsigned la, lb, keep, gone;
    n = live_nodes();
    r.taken = 1'b0;
    if (c.op == OP_CLEAR) begin
      clear_store();
      n_clears++;
    end else if (c.node_a >= 1 && c.node_a <= n && c.node_b >= 1 && c.node_b <= n) begin
      la = leader_of(c.node_a - 1);
      lb = leader_of(c.node_b - 1);
      if (la == lb) begin
        if (dup_acc != DUP_SAT) dup_acc++;
        n_dups++;
      end else begin
        keep = lb;
        gone = la;
        if (members[la] > members[lb]) begin
          keep = la;
          gone = lb;
        end
        up_link[gone] = IDX_W'(keep);
        is_leader[gone] = 1'b0;
        members[keep] = members[keep] + members[gone];
        if (cost_acc > COST_SAT - COST_W'(c.weight)) begin
          cost_acc = COST_SAT;
        end else begin
          cost_acc = cost_acc + COST_W'(c.weight);
        end
        if (tree_acc != JOIN_SAT) tree_acc++;
        r.taken = 1'b1;
        n_joins++;
      end
    end else begin
      n_ignored++;
    end
    r.cost = cost_acc;
    r.dups = dup_acc;
    r.joins = tree_acc;
    r.span = (int'(tree_acc) == n - 1);
    if (r.span) n_span++;
    return r;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit engine_busy();
    return edge_cmds.size() != 0 || in_ch.valid || totals_due.size() != 0;
  endfunction

  // sender
  always @(negedge clk) begin : drive_edges
    edge_cmd_t cmd;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left <= 0;
    end else if (in_ch.valid && !in_taken) begin
      // hold until the transfer
    end else if (gap_left != 0) begin
      in_ch.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (edge_cmds.size() != 0) begin
      cmd = edge_cmds.pop_front();
      in_ch.opcode <= cmd.op;
      in_ch.node_a <= cmd.node_a;
      in_ch.node_b <= cmd.node_b;
      in_ch.weight <= cmd.weight;
      in_ch.valid <= 1'b1;
      gap_left <= in_gaps_on ? pick_gap() : 0;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(posedge clk) begin : predict_totals
    edge_cmd_t cmd;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      cmd = '{opcode_t'(in_ch.opcode), in_ch.node_a, in_ch.node_b, in_ch.weight};
      totals_due.insert(totals_due.size(), apply_edge_cmd(cmd));
      accepted++;
    end
  end

  // receiver
  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (out_stalls_on && $urandom_range(0, 99) < 15) begin
      out_ch.ready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    totals_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (totals_due.size() == 0) begin
        report_mismatch("result transfer with no command outstanding");
      end else begin
        want = totals_due.pop_front();
        if (out_ch.edge_taken !== want.taken)
          report_mismatch($sformatf("edge_taken got %0b want %0b", out_ch.edge_taken,
                                    want.taken));
        if (out_ch.total_cost !== want.cost)
          report_mismatch($sformatf("total_cost got %0d want %0d", out_ch.total_cost,
                                    want.cost));
        if (out_ch.redundant_count !== want.dups)
          report_mismatch($sformatf("redundant_count got %0d want %0d",
                                    out_ch.redundant_count, want.dups));
        if (out_ch.tree_edges !== want.joins)
          report_mismatch($sformatf("tree_edges got %0d want %0d", out_ch.tree_edges,
                                    want.joins));
        if (out_ch.spanning !== want.span)
          report_mismatch($sformatf("spanning got %0b want %0b", out_ch.spanning,
                                    want.span));
      end
    end
  end

  // long receiver hold-off while commands are still queued
  initial begin : long_hold
    hold_off = 1'b0;
    while (!(edge_cmds.size() >= 20 && accepted >= 100)) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic push_cmd(input opcode_t op, input int unsigned a, input int unsigned b,
                          input logic [WEIGHT_W-1:0] w);
    edge_cmds.insert(edge_cmds.size(), '{op, NODE_W'(a), NODE_W'(b), w});
  endtask

  task automatic set_node_count(input logic [NODE_W-1:0] v);
    while (engine_busy()) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    node_limit = v;
    n_settings++;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned n, eff, len, p, a, b, random_done;
    longint unsigned wt, step;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_EDGE;
    in_ch.node_a = '0;
    in_ch.node_b = '0;
    in_ch.weight = '0;
    out_ch.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_taken = 1'b0;
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    node_limit = NODE_W'(NODE_RESET);
    clear_store();
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, tie and larger-set merges, ignored endpoints, clears
    push_cmd(OP_EDGE, 1, 2, 32'd0);
    push_cmd(OP_EDGE, 1024, 1023, 32'd5);
    push_cmd(OP_EDGE, 1, 1, 32'd5);
    push_cmd(OP_EDGE, 2, 1, 32'd7);
    push_cmd(OP_EDGE, 0, 3, 32'd7);
    push_cmd(OP_EDGE, 3, 1025, 32'd7);
    push_cmd(OP_EDGE, 2047, 2047, '1);
    push_cmd(OP_EDGE, 3, 1, '1);
    push_cmd(OP_EDGE, 1, 4, '1);
    push_cmd(OP_EDGE, 1023, 5, '1);
    push_cmd(OP_CLEAR, 2047, 2047, '1);
    set_node_count(1);
    push_cmd(OP_EDGE, 1, 1, 32'd0);
    push_cmd(OP_EDGE, 1, 2, 32'd0);
    set_node_count(0);
    push_cmd(OP_EDGE, 1, 1, 32'd1);
    push_cmd(OP_CLEAR, 0, 0, 32'd0);
    set_node_count(2);
    push_cmd(OP_EDGE, 2, 1, 32'd3);
    push_cmd(OP_EDGE, 1, 2, 32'd4);
    set_node_count(2047);
    push_cmd(OP_EDGE, 1024, 1, 32'd9);
    push_cmd(OP_EDGE, 1025, 1, 32'd9);

    // random graphs, mostly sorted edges over small node sets
    random_done = 0;
    while (random_done < 800) begin
      p = $urandom_range(0, 99);
      if (p < 70) begin
        n = $urandom_range(2, 24);
      end else if (p < 85) begin
        n = $urandom_range(25, 200);
      end else begin
        case ($urandom_range(0, 4))
          0: n = 0;
          1: n = 1;
          2: n = 1024;
          3: n = 2047;
          default: n = $urandom_range(1025, 2046);
        endcase
      end
      set_node_count(NODE_W'(n));
      in_gaps_on = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      eff = live_nodes();
      if ($urandom_range(0, 4) != 0) begin
        push_cmd(OP_CLEAR, $urandom, $urandom, $urandom);
        random_done++;
      end
      len = (eff <= 200) ? $urandom_range(eff, 2 * eff + 4) : $urandom_range(20, 60);
      wt = ($urandom_range(0, 3) == 0) ? longint'($urandom) : $urandom_range(0, 100);
      step = ($urandom_range(0, 1) == 0) ? 50 : (1 << 24);
      for (int i = 0; i < len; i++) begin
        p = $urandom_range(0, 99);
        if (p < 6) begin
          a = $urandom_range(0, 2047);
          b = $urandom_range(0, 2047);
          push_cmd(OP_EDGE, a, b, $urandom);
          if (a >= 1 && a <= eff && b >= 1 && b <= eff) random_done++;
        end else if (p < 10) begin
          a = $urandom_range(1, eff);
          push_cmd(OP_EDGE, a, a, WEIGHT_W'(wt));
          random_done++;
        end else if (p < 12) begin
          push_cmd(OP_CLEAR, $urandom, $urandom, $urandom);
          random_done++;
        end else if (p < 14) begin
          push_cmd(OP_EDGE, $urandom_range(1, eff), $urandom_range(1, eff), $urandom);
          random_done++;
        end else begin
          wt = wt + $urandom_range(0, step);
          if (wt > 64'hFFFF_FFFF) wt = 64'hFFFF_FFFF;
          push_cmd(OP_EDGE, $urandom_range(1, eff), $urandom_range(1, eff), WEIGHT_W'(wt));
          random_done++;
        end
      end
    end

    while (engine_busy()) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Run covered %0d commands over %0d node-count settings, %0d results checked",
             accepted, n_settings, results_seen);
    $display("Joins %0d, redundant %0d, out of range %0d, clears %0d, spanning results %0d",
             n_joins, n_dups, n_ignored, n_clears, n_span);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- kruskal_union_find_engine.f -----
+incdir+rtl
rtl/kufe_pkg.sv
rtl/kufe_in_if.sv
rtl/kufe_out_if.sv
rtl/kufe_ram.sv
rtl/kufe_dsu.sv
rtl/kufe_totals.sv
rtl/kruskal_union_find_engine.sv
tb/tb_kruskal_union_find_engine.sv
